/* src/mmt_pkg.sv */
`default_nettype none

package mmt_pkg;

  localparam int unsigned DIM_W          = 5;
  localparam int unsigned IDX_W          = 8;
  localparam int unsigned VAL_W          = 16;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 5;
  // Dimensions are at most 31, so any operand address stays below 31 * 31.
  localparam int unsigned ADDR_W         = 10;
  localparam int unsigned MN_W           = 2 * DIM_W;
  localparam int unsigned FRAC_BITS      = 8;

  localparam int unsigned MAX_DIM_DEF    = 16;
  localparam int unsigned ELEM_WIDTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_RD_C = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_M  = 3'd0,
    CFG_COLS_N  = 3'd1,
    CFG_INNER_K = 3'd2,
    CFG_TRANS_A = 3'd3,
    CFG_TRANS_B = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        flat_index;
    logic signed [VAL_W-1:0] elem_value;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [IDX_W-1:0]        result_index;
    logic                    is_last;
  } result_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* src/mmt_stream_if.sv */
`default_nettype none

interface mmt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/mmt_div.sv */
`default_nettype none

module mmt_div
  import mmt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [IDX_W-1:0] dividend_i,
  input  wire logic [DIM_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      quot_o,
  output logic [DIM_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(IDX_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIM_W:0]   rem_q, rem_d;
  logic [IDX_W-1:0] quo_q, quo_d;
  logic [DIM_W:0]   rem_sh;
  logic             fits;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q[DIM_W-1:0], quo_q[IDX_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
      quo_d = {quo_q[IDX_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(IDX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[DIM_W-1:0];

endmodule

`default_nettype wire

/* src/mmt_store.sv */
`default_nettype none

module mmt_store #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic signed [DATA_W-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic signed [DATA_W-1:0]      rdata_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/mmt_mac.sv */
`default_nettype none

module mmt_mac
  import mmt_pkg::*;
#(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  localparam int unsigned SW        = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mac_ctrl_t            ctrl_i,
  input  wire logic signed [SW-1:0] a_i,
  input  wire logic signed [SW-1:0] b_i,
  output logic                      busy_o,
  output logic signed [VAL_W-1:0]   result_o
);

  localparam int unsigned PROD_W = 2 * SW;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic                     p_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  scaled;

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= ctrl_i.en & ~ctrl_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (p_vld_q) begin
      acc_q <= acc_q + prod_ext;
    end
  end

  // Floor shift back to Q8.8, then clip to the 16-bit range.
  assign scaled = acc_q >>> FRAC_BITS;

  always_comb begin
    if (scaled > SAT_MAX) begin
      result_o = VAL_W'(SAT_MAX);
    end else if (scaled < SAT_MIN) begin
      result_o = VAL_W'(SAT_MIN);
    end else begin
      result_o = VAL_W'(scaled);
    end
  end

  assign busy_o = p_vld_q;

endmodule

`default_nettype wire

/* src/matrix_multiply_transpose_core.sv */
// Channel   Dir  Payload                                   Handshake
// req_i     in   op, flat_index, elem_value                valid / ready
// rsp_o     out  result_value, result_index, is_last       valid / ready
// cfg       in   cfg_addr_i, cfg_wdata_i                   cfg_we_i, no stall
//
// A write beat to A or B goes into its store when it is accepted. A read beat first
// splits the index into row and column with a radix-2 divider, then streams one inner
// term per cycle through the single read port of each store and the multiply-accumulate
// unit, and then drains that pipeline.
// Reset clears control state and loads the dimension registers; stores are not cleared.
// A finished result waits in the output register while the next beat is taken.
`default_nettype none

module matrix_multiply_transpose_core
  import mmt_pkg::*;
#(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mmt_stream_if.sink                 req_i,
  mmt_stream_if.source               rsp_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Configuration registers.
  logic [DIM_W-1:0] rows_m_q, cols_n_q, inner_k_q;
  logic             trans_a_q, trans_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= DIM_W'(16);
      cols_n_q  <= DIM_W'(16);
      inner_k_q <= DIM_W'(16);
      trans_a_q <= 1'b0;
      trans_b_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_ROWS_M:  rows_m_q  <= cfg_wdata_i;
        CFG_COLS_N:  cols_n_q  <= cfg_wdata_i;
        CFG_INNER_K: inner_k_q <= cfg_wdata_i;
        CFG_TRANS_A: trans_a_q <= cfg_wdata_i[0];
        CFG_TRANS_B: trans_b_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Zero counts as one, anything above the buffer size as the buffer size.
  logic [DIM_W-1:0] m_c, n_c, k_c;
  logic [MN_W-1:0]  mn;

  assign m_c = (rows_m_q == '0) ? DIM_W'(1) :
               ((32'(rows_m_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : rows_m_q);
  assign n_c = (cols_n_q == '0) ? DIM_W'(1) :
               ((32'(cols_n_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : cols_n_q);
  assign k_c = (inner_k_q == '0) ? DIM_W'(1) :
               ((32'(inner_k_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : inner_k_q);
  assign mn  = MN_W'(m_c) * MN_W'(n_c);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] a_addr_q, a_addr_d, b_addr_q, b_addr_d;
  logic [DIM_W-1:0] cnt_q, cnt_d;
  logic             s1_vld_q, s1_vld_d;
  logic             s1_oka_q, s1_oka_d, s1_okb_q, s1_okb_d;
  logic             out_vld_q, out_vld_d;
  result_t          res_q, res_d;

  logic             accept;
  logic             div_start, div_done;
  logic [IDX_W-1:0] div_quot;
  logic [DIM_W-1:0] div_rem;
  logic [DIM_W-1:0] row_i;
  logic             wr_ok, wr_a, wr_b, rd_en;
  logic [AW-1:0]    wr_addr;
  mac_ctrl_t        mac_ctrl;
  logic             mac_busy;
  logic signed [VAL_W-1:0] mac_result;
  logic signed [SW-1:0]    a_rdata, b_rdata, a_opnd, b_opnd;
  logic [ADDR_W-1:0] a_step, b_step;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;

  assign wr_ok   = 32'(req_i.data.flat_index) < DEPTH;
  assign wr_addr = AW'(req_i.data.flat_index);
  assign wr_a    = accept & wr_ok & (op_e'(req_i.data.op) == OP_WR_A);
  assign wr_b    = accept & wr_ok & (op_e'(req_i.data.op) == OP_WR_B);

  assign div_start = accept & (op_e'(req_i.data.op) == OP_RD_C) &
                     (MN_W'(req_i.data.flat_index) < mn);

  // The quotient is the row and stays below the clamped row count m_c.
  assign row_i  = DIM_W'(div_quot);
  assign a_step = trans_a_q ? ADDR_W'(m_c) : ADDR_W'(1);
  assign b_step = trans_b_q ? ADDR_W'(1) : ADDR_W'(n_c);
  assign rd_en  = (state_q == ST_RUN);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    a_addr_d  = a_addr_q;
    b_addr_d  = b_addr_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q & ~rsp_o.ready;
    res_d     = res_q;
    s1_vld_d  = 1'b0;
    s1_oka_d  = 32'(a_addr_q) < DEPTH;
    s1_okb_d  = 32'(b_addr_q) < DEPTH;
    mac_ctrl  = '{clr: 1'b0, en: s1_vld_q};
    unique case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          idx_d   = req_i.data.flat_index;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          a_addr_d     = trans_a_q ? ADDR_W'(row_i) : ADDR_W'(row_i) * ADDR_W'(k_c);
          b_addr_d     = trans_b_q ? ADDR_W'(div_rem) * ADDR_W'(k_c) : ADDR_W'(div_rem);
          cnt_d        = '0;
          mac_ctrl.clr = 1'b1;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        s1_vld_d = 1'b1;
        a_addr_d = a_addr_q + a_step;
        b_addr_d = b_addr_q + b_step;
        cnt_d    = cnt_q + DIM_W'(1);
        if (cnt_q == k_c - DIM_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !mac_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d          = 1'b1;
          res_d.result_value = mac_result;
          res_d.result_index = idx_q;
          res_d.is_last      = MN_W'(idx_q) == (mn - MN_W'(1));
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    a_addr_q <= a_addr_d;
    b_addr_q <= b_addr_d;
    s1_oka_q <= s1_oka_d;
    s1_okb_q <= s1_okb_d;
    res_q    <= res_d;
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = res_q;

  mmt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.data.flat_index),
    .divisor_i  (n_c),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  mmt_store #(
    .DEPTH  (DEPTH),
    .DATA_W (SW)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (wr_addr),
    .wdata_i (req_i.data.elem_value[SW-1:0]),
    .re_i    (rd_en),
    .raddr_i (AW'(a_addr_q)),
    .rdata_o (a_rdata)
  );

  mmt_store #(
    .DEPTH  (DEPTH),
    .DATA_W (SW)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (wr_addr),
    .wdata_i (req_i.data.elem_value[SW-1:0]),
    .re_i    (rd_en),
    .raddr_i (AW'(b_addr_q)),
    .rdata_o (b_rdata)
  );

  // An address past the end of a store reads as zero.
  assign a_opnd = s1_oka_q ? a_rdata : '0;
  assign b_opnd = s1_okb_q ? b_rdata : '0;

  mmt_mac #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_i      (a_opnd),
    .b_i      (b_opnd),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_matrix_multiply_transpose_core.sv */
`timescale 1ns / 100ps

module tb_matrix_multiply_transpose_core;
  import mmt_pkg::*;

  localparam int unsigned STORE_DEPTH    = MAX_DIM_DEF * MAX_DIM_DEF;
  // Long enough for a read at the largest clamped size to finish.
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned ITEM_TARGET    = 1200;
  localparam int unsigned QUIET_TAIL     = 150;
  localparam int unsigned N_DIRECTED     = 23;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  localparam item_t   NO_BEAT   = '0;
  localparam result_t NO_RESULT = '0;

  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_e              cfg_sel;
    logic [CFG_DATA_W-1:0] cfg_val;
    item_t                 beat;
    logic                  typed;
    result_t               want;
  } step_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mmt_stream_if #(.T(item_t))   req_if ();
  mmt_stream_if #(.T(result_t)) rsp_if ();

  matrix_multiply_transpose_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow copy of the block: both operand stores and the dimension registers.
  logic signed [VAL_W-1:0] a_mirror [STORE_DEPTH];
  logic signed [VAL_W-1:0] b_mirror [STORE_DEPTH];
  bit                      a_loaded [STORE_DEPTH];
  bit                      b_loaded [STORE_DEPTH];
  logic [DIM_W-1:0]        m_reg = 5'd16;
  logic [DIM_W-1:0]        n_reg = 5'd16;
  logic [DIM_W-1:0]        k_reg = 5'd16;
  logic                    ta_reg = 1'b0;
  logic                    tb_reg = 1'b0;

  result_t     pending_c [$];
  result_t     due;
  int unsigned fail_count    = 0;
  int unsigned beats_counted = 0;
  bit          quiet         = 1'b0;
  int unsigned idle_edges;

  // The trans flags stay at their reset values here, and every case uses a 1 by 1 product.
  step_row_t directed_plan [N_DIRECTED] = '{
    '{1'b1, CFG_ROWS_M,  5'd0, NO_BEAT, 1'b0, NO_RESULT},
    '{1'b1, CFG_COLS_N,  5'd1, NO_BEAT, 1'b0, NO_RESULT},
    '{1'b1, CFG_INNER_K, 5'd1, NO_BEAT, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_A, 8'd0, 16'sh0100}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_B, 8'd0, 16'sh0200}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_RD_C, 8'd0, 16'sh0000}, 1'b1, '{16'sh0200, 8'd0, 1'b1}},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_RD_C, 8'd1, 16'sh1234}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_UNUSED, 8'd0, 16'sh7FFF}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_A, 8'd0, 16'sh7FFF}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_B, 8'd0, 16'sh7FFF}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_RD_C, 8'd0, 16'sh0000}, 1'b1, '{16'sh7FFF, 8'd0, 1'b1}},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_B, 8'd0, 16'sh8000}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_RD_C, 8'd0, 16'sh0000}, 1'b1, '{16'sh8000, 8'd0, 1'b1}},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_A, 8'd0, 16'sh8000}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_RD_C, 8'd0, 16'sh0000}, 1'b1, '{16'sh7FFF, 8'd0, 1'b1}},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_A, 8'd0, 16'shFFFF}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_B, 8'd0, 16'sh0001}, 1'b0, NO_RESULT},
    // A product of -1 rounds toward minus infinity, not toward zero.
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_RD_C, 8'd0, 16'sh0000}, 1'b1, '{16'shFFFF, 8'd0, 1'b1}},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_A, 8'd0, 16'sh0001}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_RD_C, 8'd0, 16'shFFFF}, 1'b1, '{16'sh0000, 8'd0, 1'b1}},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_A, 8'd255, 16'sh5A5A}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_WR_B, 8'd255, 16'shA5A5}, 1'b0, NO_RESULT},
    '{1'b0, CFG_ROWS_M, 5'd0, '{OP_RD_C, 8'd255, 16'sh0000}, 1'b0, NO_RESULT}
  };

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return int'(MAX_DIM_DEF);
    return int'(v);
  endfunction

  // Dot product of row i of op(A) and column j of op(B), floored and saturated.
  function automatic bit gemm_element(input logic [IDX_W-1:0] idx, output result_t res);
    int     m, n, k, row, col, ai, bi;
    longint acc, q;
    m = eff_dim(m_reg);
    n = eff_dim(n_reg);
    k = eff_dim(k_reg);
    if (int'(idx) >= m * n) return 1'b0;
    row = int'(idx) / n;
    col = int'(idx) % n;
    acc = 0;
    for (int l = 0; l < k; l++) begin
      ai = ta_reg ? l * m + row : row * k + l;
      bi = tb_reg ? col * k + l : l * n + col;
      acc += longint'(a_mirror[ai]) * longint'(b_mirror[bi]);
    end
    q = acc >>> FRAC_BITS;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res.result_value = q[VAL_W-1:0];
    res.result_index = idx;
    res.is_last      = (int'(idx) == m * n - 1);
    return 1'b1;
  endfunction

  task automatic absorb_beat(item_t beat, bit typed, result_t want);
    result_t got;
    case (beat.op)
      OP_WR_A: begin
        a_mirror[beat.flat_index] = beat.elem_value;
        a_loaded[beat.flat_index] = 1'b1;
        beats_counted++;
      end
      OP_WR_B: begin
        b_mirror[beat.flat_index] = beat.elem_value;
        b_loaded[beat.flat_index] = 1'b1;
        beats_counted++;
      end
      OP_RD_C: begin
        if (gemm_element(beat.flat_index, got)) begin
          pending_c.push_back(typed ? want : got);
          beats_counted++;
        end
      end
      default: ;
    endcase
  endtask

  // Valid stays high after the handshake so that beats can follow back to back.
  task automatic send_beat(item_t beat, bit typed, result_t want);
    req_if.valid <= 1'b1;
    req_if.data  <= beat;
    do @(posedge clk_i); while (!req_if.ready);
    absorb_beat(beat, typed, want);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 9) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic issue(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] value);
    item_t beat;
    beat.op         = op;
    beat.flat_index = idx;
    beat.elem_value = value;
    send_beat(beat, 1'b0, NO_RESULT);
    quiet = (beats_counted + QUIET_TAIL >= ITEM_TARGET);
    maybe_gap();
  endtask

  // Registers change only once every read has answered and the core has drained.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_c.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e sel, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (sel)
      CFG_ROWS_M:  m_reg  = value;
      CFG_COLS_N:  n_reg  = value;
      CFG_INNER_K: k_reg  = value;
      CFG_TRANS_A: ta_reg = value[0];
      CFG_TRANS_B: tb_reg = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    if (r <= 2) return VAL_W'($urandom);
    return VAL_W'($urandom_range(0, 1024) - 512);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'd31;
    if (r == 2) return 5'd16;
    if (r <= 5) return DIM_W'($urandom_range(6, 16));
    return DIM_W'($urandom_range(1, 5));
  endfunction

  // One setting: load every entry that op(A) and op(B) can touch, then mix reads and writes.
  task automatic run_phase(logic [DIM_W-1:0] m_set, logic [DIM_W-1:0] n_set,
                           logic [DIM_W-1:0] k_set, logic ta_set, logic tb_set);
    int          m, n, k, mix;
    int unsigned count;
    settle();
    write_reg(CFG_ROWS_M, m_set);
    write_reg(CFG_COLS_N, n_set);
    write_reg(CFG_INNER_K, k_set);
    write_reg(CFG_TRANS_A, {4'd0, ta_set});
    write_reg(CFG_TRANS_B, {4'd0, tb_set});
    m = eff_dim(m_reg);
    n = eff_dim(n_reg);
    k = eff_dim(k_reg);
    for (int e = 0; e < m * k; e++)
      if (!a_loaded[e] || $urandom_range(0, 2) == 0) issue(OP_WR_A, IDX_W'(e), pick_value());
    for (int e = 0; e < k * n; e++)
      if (!b_loaded[e] || $urandom_range(0, 2) == 0) issue(OP_WR_B, IDX_W'(e), pick_value());
    count = $urandom_range(12, 40);
    repeat (count) begin
      mix = $urandom_range(0, 99);
      if (mix < 55)
        issue(OP_RD_C, IDX_W'($urandom_range(0, m * n - 1)), VAL_W'($urandom));
      else if (mix < 70)
        issue(OP_WR_A, IDX_W'($urandom), pick_value());
      else if (mix < 85)
        issue(OP_WR_B, IDX_W'($urandom), pick_value());
      else if (mix < 93)
        issue(OP_RD_C, IDX_W'($urandom), VAL_W'($urandom));
      else
        issue(OP_UNUSED, IDX_W'($urandom), VAL_W'($urandom));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_cfg) begin
        settle();
        write_reg(directed_plan[r].cfg_sel, directed_plan[r].cfg_val);
      end else begin
        send_beat(directed_plan[r].beat, directed_plan[r].typed, directed_plan[r].want);
        maybe_gap();
      end
    end

    // Clamped extremes first: both flags set with a 16 deep dot product, then 1 by 16.
    run_phase(5'd31, 5'd0, 5'd16, 1'b1, 1'b1);
    run_phase(5'd0, 5'd31, 5'd0, 1'b0, 1'b1);
    while (beats_counted < ITEM_TARGET)
      run_phase(pick_dim(), pick_dim(), pick_dim(), 1'($urandom), 1'($urandom));

    req_if.valid <= 1'b0;
    while (pending_c.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb_matrix_multiply_transpose_core: done, clean");
    else
      $display("tb_matrix_multiply_transpose_core: done, errors");
    $finish;
  end

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_c.size() == 0) begin
        $error("unexpected result beat at index %0d", rsp_if.data.result_index);
        fail_count++;
      end else begin
        due = pending_c.pop_front();
        if (rsp_if.data.result_value !== due.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 $signed(due.result_value), $signed(rsp_if.data.result_value));
          fail_count++;
        end
        if (rsp_if.data.result_index !== due.result_index) begin
          $error("result_index: expected %0d, got %0d",
                 due.result_index, rsp_if.data.result_index);
          fail_count++;
        end
        if (rsp_if.data.is_last !== due.is_last) begin
          $error("is_last: expected %0d, got %0d", due.is_last, rsp_if.data.is_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    idle_edges = 0;
    while (idle_edges < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_edges = 0;
      else
        idle_edges++;
    end
    $display("tb_matrix_multiply_transpose_core: done, errors");
    $finish;
  end

endmodule
